// ===== sv/aarm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the axis-angle matrix block.
package aarm_pkg;

   localparam int NORM_STEPS   = 5;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 31;
   localparam int CORDIC_STEPS = 30;
   // input, magnitude, square, sum, normalise, shift, sqrt, divider set-up, divide, six math stages
   localparam int LATENCY = 4 + NORM_STEPS + 1 + SQRT_STEPS + 1 + DIV_STEPS + 6;

   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE   = 34'sd1073741824;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   typedef struct packed {
      logic             zero;
      logic [2:0]       neg;
      logic [31:0]      phase;
      logic [2:0][31:0] num;
   } side_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [2:0][62:0] rem;
      logic [2:0][30:0] quo;
      logic [31:0]      len;
   } div_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
      logic [1:0]         quad;
   } cordic_type;

   function automatic logic [29:0] atan_q30(input int i);
      logic [29:0] r;
      case (i)
         0:  r = 30'h20000000;
         1:  r = 30'h12E4051E;
         2:  r = 30'h09FB385B;
         3:  r = 30'h051111D4;
         4:  r = 30'h028B0D43;
         5:  r = 30'h0145D7E1;
         6:  r = 30'h00A2F61E;
         7:  r = 30'h00517C55;
         8:  r = 30'h0028BE53;
         9:  r = 30'h00145F2F;
         10: r = 30'h000A2F98;
         11: r = 30'h000517CC;
         12: r = 30'h00028BE6;
         13: r = 30'h000145F3;
         14: r = 30'h0000A2FA;
         15: r = 30'h0000517D;
         16: r = 30'h000028BE;
         17: r = 30'h0000145F;
         18: r = 30'h00000A30;
         19: r = 30'h00000518;
         20: r = 30'h0000028C;
         21: r = 30'h00000146;
         22: r = 30'h000000A3;
         23: r = 30'h00000051;
         24: r = 30'h00000029;
         25: r = 30'h00000014;
         26: r = 30'h0000000A;
         27: r = 30'h00000005;
         28: r = 30'h00000003;
         29: r = 30'h00000001;
         default: r = 30'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/aarm_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One bit-pair step of the integer square root chain.
module aarm_sqrt_cell import aarm_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     en,
   input  sqrt_type sq_i,
   input  side_type side_i,
   output sqrt_type sq_o,
   output side_type side_o
);

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   logic [63:0] trial;
   sqrt_type    sq_in, sq_ff;
   side_type    side_ff;

   always_comb begin
      trial = sq_i.root + BIT;
      if (sq_i.rem >= trial) begin
         sq_in.rem  = sq_i.rem - trial;
         sq_in.root = (sq_i.root >> 1) + BIT;
      end else begin
         sq_in.rem  = sq_i.rem;
         sq_in.root = sq_i.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         side_ff <= side_i;
      end
   end

   assign sq_o   = sq_ff;
   assign side_o = side_ff;

endmodule

// ===== sv/aarm_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring-division step for the three axis lanes.
module aarm_div_cell import aarm_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     en,
   input  div_type  d_i,
   input  side_type side_i,
   output div_type  d_o,
   output side_type side_o
);

   localparam int SH = DIV_STEPS - 1 - STEP;

   logic [62:0] dv;
   div_type     d_in, d_ff;
   side_type    side_ff;

   always_comb begin
      dv   = 63'(d_i.len) << SH;
      d_in = d_i;
      for (int l = 0; l < 3; l++) begin
         if (d_i.rem[l] >= dv) begin
            d_in.rem[l] = d_i.rem[l] - dv;
            d_in.quo[l] = {d_i.quo[l][29:0], 1'b1};
         end else begin
            d_in.quo[l] = {d_i.quo[l][29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         side_ff <= side_i;
      end
   end

   assign d_o    = d_ff;
   assign side_o = side_ff;

endmodule

// ===== sv/aarm_cordic_cell.sv =====
`timescale 1ns / 1ps
// One micro-rotation of the sine/cosine CORDIC chain.
module aarm_cordic_cell import aarm_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       en,
   input  cordic_type c_i,
   output cordic_type c_o
);

   logic signed [33:0] dx, dy;
   logic signed [32:0] at;
   cordic_type         c_in, c_ff;

   always_comb begin
      dx   = c_i.y >>> STEP;
      dy   = c_i.x >>> STEP;
      at   = 33'(atan_q30(STEP));
      c_in = c_i;
      if (!c_i.z[32]) begin
         c_in.x = c_i.x - dx;
         c_in.y = c_i.y + dy;
         c_in.z = c_i.z - at;
      end else begin
         c_in.x = c_i.x + dx;
         c_in.y = c_i.y - dy;
         c_in.z = c_i.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
      end
   end

   assign c_o = c_ff;

endmodule

// ===== sv/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// Axis-angle to rotation matrix (Rodrigues). Takes one word per cycle and returns one word per
// cycle while rsp_tready lets the pipe advance. The pipe is a chain of cells: 32 square-root
// cells that find the axis length and 31 divider cells that scale each component to unit length,
// with the 30 CORDIC cells for sine and cosine running beside the divider. Entries come out in
// signed Q2.(OUT_WIDTH-2), saturated. An all-zero axis gives the identity with the flag in tuser.
// The whole pipe holds while a finished word waits on rsp_tready.
module axis_angle_rotation_matrix import aarm_pkg::*; #(
   parameter int AXIS_WIDTH  = 16,
   parameter int ANGLE_WIDTH = 16,
   parameter int OUT_WIDTH   = 16,
   localparam int REQ_W = ((3 * AXIS_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((9 * OUT_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // axis_x, axis_y, axis_z, angle
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic             rsp_tuser   // zero_axis
);

   localparam int AW = AXIS_WIDTH;
   localparam int SH = 32 - OUT_WIDTH;
   localparam logic signed [36:0] RND = (37'sd1 <<< SH) >>> 1;
   localparam logic signed [36:0] HI  = (37'sd1 <<< (OUT_WIDTH - 1)) - 37'sd1;
   localparam logic signed [36:0] LO  = -HI - 37'sd1;
   localparam logic [OUT_WIDTH-1:0] ONE = OUT_WIDTH'(1) << (OUT_WIDTH - 2);

   logic adv;
   logic [LATENCY-1:0] vld_ff;

   assign adv        = !vld_ff[LATENCY-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_tvalid};
      end
   end

   // front end: capture, magnitude, square, sum
   logic [2:0][AW-1:0]   ax0_ff, mag1_ff, mag2_ff;
   logic [2:0][2*AW-1:0] sq2_ff;
   logic [2:0]           neg1_ff, neg2_ff;
   logic [31:0]          ph0_ff, ph1_ff, ph2_ff;
   logic [2:0][AW-1:0]   mag1_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag1_in[l] = ax0_ff[l][AW-1] ? (~ax0_ff[l] + AW'(1)) : ax0_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            ax0_ff[l]  <= req_tdata[l*AW +: AW];
            mag1_ff[l] <= mag1_in[l];
            neg1_ff[l] <= ax0_ff[l][AW-1];
            sq2_ff[l]  <= mag1_ff[l] * mag1_ff[l];
         end
         ph0_ff  <= 32'(req_tdata[3*AW +: ANGLE_WIDTH]) << (32 - ANGLE_WIDTH);
         ph1_ff  <= ph0_ff;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         ph2_ff  <= ph1_ff;
      end
   end

   // normalise: shift the sum left by pairs of bits until bit 60 or above is set
   logic [63:0]          nrm_s_ff   [0:NORM_STEPS];
   logic [4:0]           nrm_k_ff   [0:NORM_STEPS];
   logic [2:0][AW-1:0]   nrm_mag_ff [0:NORM_STEPS];
   logic [2:0]           nrm_neg_ff [0:NORM_STEPS];
   logic [31:0]          nrm_ph_ff  [0:NORM_STEPS];
   logic                 nrm_z_ff   [0:NORM_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         nrm_s_ff[0]   <= 64'(sq2_ff[0]) + 64'(sq2_ff[1]) + 64'(sq2_ff[2]);
         nrm_k_ff[0]   <= 5'd0;
         nrm_mag_ff[0] <= mag2_ff;
         nrm_neg_ff[0] <= neg2_ff;
         nrm_ph_ff[0]  <= ph2_ff;
         nrm_z_ff[0]   <= (sq2_ff == '0);
      end
   end

   for (genvar n = 0; n < NORM_STEPS; n++) begin : g_norm
      localparam int D = 16 >> n;
      logic [63:0] s_in;
      logic [4:0]  k_in;

      always_comb begin
         if ((nrm_s_ff[n] >> (62 - 2 * D)) == 64'd0) begin
            s_in = nrm_s_ff[n] << (2 * D);
            k_in = nrm_k_ff[n] + 5'(D);
         end else begin
            s_in = nrm_s_ff[n];
            k_in = nrm_k_ff[n];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nrm_s_ff[n+1]   <= s_in;
            nrm_k_ff[n+1]   <= k_in;
            nrm_mag_ff[n+1] <= nrm_mag_ff[n];
            nrm_neg_ff[n+1] <= nrm_neg_ff[n];
            nrm_ph_ff[n+1]  <= nrm_ph_ff[n];
            nrm_z_ff[n+1]   <= nrm_z_ff[n];
         end
      end
   end

   // square root chain
   sqrt_type sq_c [0:SQRT_STEPS];
   side_type sd_c [0:SQRT_STEPS];
   sqrt_type sq0_ff;
   side_type sd0_ff, sd0_in;

   always_comb begin
      sd0_in.zero  = nrm_z_ff[NORM_STEPS];
      sd0_in.neg   = nrm_neg_ff[NORM_STEPS];
      sd0_in.phase = nrm_ph_ff[NORM_STEPS];
      for (int l = 0; l < 3; l++) begin
         sd0_in.num[l] = 32'(nrm_mag_ff[NORM_STEPS][l]) << nrm_k_ff[NORM_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq0_ff.rem  <= nrm_s_ff[NORM_STEPS];
         sq0_ff.root <= 64'd0;
         sd0_ff      <= sd0_in;
      end
   end

   assign sq_c[0] = sq0_ff;
   assign sd_c[0] = sd0_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      aarm_sqrt_cell #(.STEP(i)) u_cell (
         .clock  (clock),
         .en     (adv),
         .sq_i   (sq_c[i]),
         .side_i (sd_c[i]),
         .sq_o   (sq_c[i+1]),
         .side_o (sd_c[i+1])
      );
   end

   // divider set-up and CORDIC start
   div_type    dv_c [0:DIV_STEPS];
   side_type   dd_c [0:DIV_STEPS];
   cordic_type cr_c [0:CORDIC_STEPS];
   div_type    dv0_ff, dv0_in;
   side_type   dd0_ff;
   cordic_type cr0_ff, cr_al_ff;
   logic [31:0] len;

   assign len = sq_c[SQRT_STEPS].root[31:0];

   always_comb begin
      dv0_in.len = len;
      dv0_in.quo = '0;
      for (int l = 0; l < 3; l++) begin
         // round half up: add half the divisor before dividing
         dv0_in.rem[l] = (63'(sd_c[SQRT_STEPS].num[l]) << 30) + 63'(len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv0_ff      <= dv0_in;
         dd0_ff      <= sd_c[SQRT_STEPS];
         cr0_ff.x    <= CORDIC_X0;
         cr0_ff.y    <= 34'sd0;
         cr0_ff.z    <= 33'(sd_c[SQRT_STEPS].phase[29:0]);
         cr0_ff.quad <= sd_c[SQRT_STEPS].phase[31:30];
         cr_al_ff    <= cr_c[CORDIC_STEPS];
      end
   end

   assign dv_c[0] = dv0_ff;
   assign dd_c[0] = dd0_ff;
   assign cr_c[0] = cr0_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      aarm_div_cell #(.STEP(i)) u_cell (
         .clock  (clock),
         .en     (adv),
         .d_i    (dv_c[i]),
         .side_i (dd_c[i]),
         .d_o    (dv_c[i+1]),
         .side_o (dd_c[i+1])
      );
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      aarm_cordic_cell #(.STEP(i)) u_cell (
         .clock (clock),
         .en    (adv),
         .c_i   (cr_c[i]),
         .c_o   (cr_c[i+1])
      );
   end

   // matrix math
   logic signed [31:0] a0_ff [3];
   logic signed [33:0] co0_ff, si0_ff, t0_ff;
   logic               z0_ff;
   logic signed [31:0] a0_in [3];
   logic signed [33:0] co0_in, si0_in;
   logic [30:0]        qc;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         qc = (dv_c[DIV_STEPS].quo[l] > 31'h40000000) ? 31'h40000000
                                                       : dv_c[DIV_STEPS].quo[l];
         a0_in[l] = dd_c[DIV_STEPS].neg[l] ? -$signed(32'(qc)) : $signed(32'(qc));
      end
      case (cr_al_ff.quad)
         QUAD_0: begin
            co0_in = cr_al_ff.x;
            si0_in = cr_al_ff.y;
         end
         QUAD_1: begin
            co0_in = -cr_al_ff.y;
            si0_in = cr_al_ff.x;
         end
         QUAD_2: begin
            co0_in = -cr_al_ff.x;
            si0_in = -cr_al_ff.y;
         end
         default: begin
            co0_in = cr_al_ff.y;
            si0_in = -cr_al_ff.x;
         end
      endcase
   end

   logic signed [63:0] pr1_ff [6];
   logic signed [65:0] ps1_ff [3];
   logic signed [33:0] co1_ff, t1_ff;
   logic               z1_ff;
   logic signed [31:0] rp2_ff [6];
   logic signed [33:0] rs2_ff [3];
   logic signed [33:0] co2_ff, t2_ff;
   logic               z2_ff;
   logic signed [65:0] tp3_ff [6];
   logic signed [33:0] rs3_ff [3];
   logic signed [33:0] co3_ff;
   logic               z3_ff;
   logic signed [35:0] m4_ff [9];
   logic               z4_ff;
   logic signed [35:0] rt [6];
   logic signed [35:0] cx, sx [3];
   logic [OUT_WIDTH-1:0] out5_ff [9];
   logic [OUT_WIDTH-1:0] out5_in [9];
   logic                 z5_ff;
   logic signed [36:0]   rv;

   always_comb begin
      cx = 36'(co3_ff);
      for (int l = 0; l < 3; l++) begin
         sx[l] = 36'(rs3_ff[l]);
      end
      for (int p = 0; p < 6; p++) begin
         rt[p] = 36'((tp3_ff[p] + 66'sd536870912) >>> 30);
      end
   end

   always_comb begin
      for (int e = 0; e < 9; e++) begin
         rv = (37'(m4_ff[e]) + RND) >>> SH;
         if (rv > HI) begin
            out5_in[e] = HI[OUT_WIDTH-1:0];
         end else if (rv < LO) begin
            out5_in[e] = LO[OUT_WIDTH-1:0];
         end else begin
            out5_in[e] = rv[OUT_WIDTH-1:0];
         end
         if (z4_ff) begin
            out5_in[e] = (e == 0 || e == 4 || e == 8) ? ONE : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a0_ff  <= a0_in;
         co0_ff <= co0_in;
         si0_ff <= si0_in;
         t0_ff  <= Q30_ONE - co0_in;
         z0_ff  <= dd_c[DIV_STEPS].zero;

         // pair order: aa, ab, ac, bb, bc, cc
         pr1_ff[0] <= a0_ff[0] * a0_ff[0];
         pr1_ff[1] <= a0_ff[0] * a0_ff[1];
         pr1_ff[2] <= a0_ff[0] * a0_ff[2];
         pr1_ff[3] <= a0_ff[1] * a0_ff[1];
         pr1_ff[4] <= a0_ff[1] * a0_ff[2];
         pr1_ff[5] <= a0_ff[2] * a0_ff[2];
         for (int l = 0; l < 3; l++) begin
            ps1_ff[l] <= 66'(a0_ff[l]) * 66'(si0_ff);
         end
         co1_ff <= co0_ff;
         t1_ff  <= t0_ff;
         z1_ff  <= z0_ff;

         for (int p = 0; p < 6; p++) begin
            rp2_ff[p] <= 32'((pr1_ff[p] + 64'sd536870912) >>> 30);
         end
         for (int l = 0; l < 3; l++) begin
            rs2_ff[l] <= 34'((ps1_ff[l] + 66'sd536870912) >>> 30);
         end
         co2_ff <= co1_ff;
         t2_ff  <= t1_ff;
         z2_ff  <= z1_ff;

         for (int p = 0; p < 6; p++) begin
            tp3_ff[p] <= 66'(t2_ff) * 66'(rp2_ff[p]);
         end
         rs3_ff <= rs2_ff;
         co3_ff <= co2_ff;
         z3_ff  <= z2_ff;

         m4_ff[0] <= rt[0] + cx;
         m4_ff[1] <= rt[1] - sx[2];
         m4_ff[2] <= rt[2] + sx[1];
         m4_ff[3] <= rt[1] + sx[2];
         m4_ff[4] <= rt[3] + cx;
         m4_ff[5] <= rt[4] - sx[0];
         m4_ff[6] <= rt[2] - sx[1];
         m4_ff[7] <= rt[4] + sx[0];
         m4_ff[8] <= rt[5] + cx;
         z4_ff    <= z3_ff;

         out5_ff <= out5_in;
         z5_ff   <= z4_ff;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int e = 0; e < 9; e++) begin
         rsp_tdata[e*OUT_WIDTH +: OUT_WIDTH] = out5_ff[e];
      end
   end

   assign rsp_tuser = z5_ff;

endmodule

// ===== sv/aarm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the axis-angle matrix block, bound to its top level.
module aarm_checker #(
   parameter int OUT_WIDTH = 16,
   localparam int RSP_W = ((9 * OUT_WIDTH + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);

   localparam logic [OUT_WIDTH-1:0] ONE = OUT_WIDTH'(1) << (OUT_WIDTH - 2);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // zero axis gives the identity: ones on the diagonal and m01 zero
   a_zero_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[0 +: OUT_WIDTH] == ONE && rsp_tdata[4*OUT_WIDTH +: OUT_WIDTH] == ONE &&
         rsp_tdata[8*OUT_WIDTH +: OUT_WIDTH] == ONE && rsp_tdata[OUT_WIDTH +: OUT_WIDTH] == '0)
      else $error("zero axis without identity");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input held off with empty output");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while pipe stalled");

endmodule

bind axis_angle_rotation_matrix aarm_checker #(.OUT_WIDTH(OUT_WIDTH)) u_aarm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
